>>> design/spq_pkg.sv
// shared types and codes for the stable priority queue
`timescale 1ns / 1ps

package spq_pkg;

	localparam int CMD_W    = 2;
	localparam int STATUS_W = 2;
	localparam int ID_W     = 32;
	localparam int PRIO_W   = 8;
	localparam int OCC_W    = 5;
	localparam int IN_W     = 48;
	localparam int OUT_W    = 48;

	typedef logic [CMD_W-1:0]    cmd_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam cmd_t CMD_INSERT = 2'd0;
	localparam cmd_t CMD_REMOVE = 2'd1;
	localparam cmd_t CMD_LOOKUP = 2'd2;

	localparam status_t ST_OK       = 2'd0;
	localparam status_t ST_EMPTY    = 2'd1;
	localparam status_t ST_FULL     = 2'd2;
	localparam status_t ST_NOTFOUND = 2'd3;

endpackage

>>> design/stable_priority_queue.sv
// stable priority queue: sorted entry memory scanned by a small sequencer
`timescale 1ns / 1ps

// Bounded queue of (id, priority) entries held in a single-port-read entry memory in
// sorted order, smallest priority first, equal priorities in arrival order. One request
// is taken at a time; s_tready drops from acceptance until its result has been taken.
// Each request walks the memory one entry per cycle through the registered read port:
// an insert into a non-empty queue scans from the tail toward the front, moving larger
// entries back one place, and lands at the front through S_INS_HEAD when all move; remove
// shifts every held entry forward and lookup stops at the first matching id. An insert
// into an empty or a full queue, a remove or lookup on an empty queue and the unused
// command code finish without a scan. The memory needs no clearing after reset.
module stable_priority_queue #(
	parameter int CAPACITY   = 16,
	parameter int ID_WIDTH   = 32,
	parameter int PRIO_WIDTH = 8
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	input  logic [spq_pkg::IN_W-1:0]  s_tdata,  // command, client_id, priority_req
	output logic                    m_tvalid,
	input  logic                    m_tready,
	output logic [spq_pkg::OUT_W-1:0] m_tdata   // status, out_id, out_priority, occupancy
);

	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CNT_W = $clog2(CAPACITY + 1);

	typedef enum logic [2:0] {
		S_IDLE,
		S_INS,
		S_INS_HEAD,
		S_REM,
		S_LKP,
		S_RESP
	} state_t;

	state_t state_q;

	// entry memory
	logic [ID_WIDTH-1:0]   mem_id [CAPACITY];
	logic [PRIO_WIDTH-1:0] mem_pr [CAPACITY];
	logic [ID_WIDTH-1:0]   rd_id_q;
	logic [PRIO_WIDTH-1:0] rd_pr_q;

	logic                  mem_we;
	logic [IDX_W-1:0]      mem_wa;
	logic [ID_WIDTH-1:0]   mem_wid;
	logic [PRIO_WIDTH-1:0] mem_wpr;
	logic                  mem_re;
	logic [IDX_W-1:0]      mem_ra;

	logic [CNT_W-1:0]      cnt_q;
	logic [IDX_W-1:0]      idx_q;
	logic [ID_WIDTH-1:0]   req_id_q;
	logic [PRIO_WIDTH-1:0] req_pr_q;

	logic                         out_vld_q;
	spq_pkg::status_t             out_st_q;
	logic [spq_pkg::ID_W-1:0]     out_id_q;
	logic [spq_pkg::PRIO_W-1:0]   out_pr_q;

	spq_pkg::cmd_t         in_cmd;
	logic [ID_WIDTH-1:0]   in_id;
	logic [PRIO_WIDTH-1:0] in_pr;
	logic                  accept;
	logic                  shift;
	logic                  more;
	logic                  hit;

	assign in_cmd = s_tdata[1:0];
	assign in_id  = ID_WIDTH'(s_tdata[33:2]);
	assign in_pr  = PRIO_WIDTH'(s_tdata[41:34]);

	assign s_tready = (state_q == S_IDLE) && !out_vld_q;
	assign accept   = s_tvalid && s_tready;

	// the compares used in the scan steps
	assign shift = rd_pr_q > req_pr_q;
	assign hit   = rd_id_q == req_id_q;
	assign more  = (CNT_W'(idx_q) + CNT_W'(1)) < cnt_q;

	always_comb begin
		mem_we  = 1'b0;
		mem_wa  = '0;
		mem_wid = req_id_q;
		mem_wpr = req_pr_q;
		mem_re  = 1'b0;
		mem_ra  = '0;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (in_cmd)
						spq_pkg::CMD_INSERT: begin
							if (cnt_q == '0) begin
								mem_we  = 1'b1;
								mem_wid = in_id;
								mem_wpr = in_pr;
							end else if (cnt_q < CNT_W'(CAPACITY)) begin
								mem_re = 1'b1;
								mem_ra = IDX_W'(cnt_q - CNT_W'(1));
							end
						end
						spq_pkg::CMD_REMOVE, spq_pkg::CMD_LOOKUP: begin
							mem_re = cnt_q != '0;
						end
						default: ;
					endcase
				end
			end
			S_INS: begin
				mem_we = 1'b1;
				mem_wa = idx_q + IDX_W'(1);
				if (shift) begin
					mem_wid = rd_id_q;
					mem_wpr = rd_pr_q;
					mem_re  = idx_q != '0;
					mem_ra  = idx_q - IDX_W'(1);
				end
			end
			S_INS_HEAD: begin
				mem_we = 1'b1;
			end
			S_REM: begin
				mem_we  = idx_q != '0;
				mem_wa  = idx_q - IDX_W'(1);
				mem_wid = rd_id_q;
				mem_wpr = rd_pr_q;
				mem_re  = more;
				mem_ra  = idx_q + IDX_W'(1);
			end
			S_LKP: begin
				mem_re = !hit && more;
				mem_ra = idx_q + IDX_W'(1);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_id[mem_wa] <= mem_wid;
			mem_pr[mem_wa] <= mem_wpr;
		end
		if (mem_re) begin
			rd_id_q <= mem_id[mem_ra];
			rd_pr_q <= mem_pr[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			out_vld_q <= 1'b0;
			idx_q     <= '0;
			req_id_q  <= '0;
			req_pr_q  <= '0;
			out_st_q  <= spq_pkg::ST_OK;
			out_id_q  <= '0;
			out_pr_q  <= '0;
		end else begin
			if (out_vld_q && m_tready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						req_id_q <= in_id;
						req_pr_q <= in_pr;
						out_st_q <= spq_pkg::ST_OK;
						out_id_q <= '0;
						out_pr_q <= '0;
						idx_q    <= '0;
						case (in_cmd)
							spq_pkg::CMD_INSERT: begin
								if (cnt_q >= CNT_W'(CAPACITY)) begin
									out_st_q  <= spq_pkg::ST_FULL;
									out_vld_q <= 1'b1;
								end else if (cnt_q == '0) begin
									cnt_q     <= CNT_W'(1);
									out_vld_q <= 1'b1;
								end else begin
									idx_q   <= IDX_W'(cnt_q - CNT_W'(1));
									state_q <= S_INS;
								end
							end
							spq_pkg::CMD_REMOVE: begin
								if (cnt_q == '0) begin
									out_st_q  <= spq_pkg::ST_EMPTY;
									out_vld_q <= 1'b1;
								end else begin
									state_q <= S_REM;
								end
							end
							spq_pkg::CMD_LOOKUP: begin
								if (cnt_q == '0) begin
									out_st_q  <= spq_pkg::ST_NOTFOUND;
									out_vld_q <= 1'b1;
								end else begin
									state_q <= S_LKP;
								end
							end
							default: begin
								out_vld_q <= 1'b1;
							end
						endcase
					end
				end
				S_INS: begin
					if (shift && idx_q != '0) begin
						idx_q <= idx_q - IDX_W'(1);
					end else if (shift) begin
						state_q <= S_INS_HEAD;
					end else begin
						cnt_q     <= cnt_q + CNT_W'(1);
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				S_INS_HEAD: begin
					cnt_q     <= cnt_q + CNT_W'(1);
					out_vld_q <= 1'b1;
					state_q   <= S_IDLE;
				end
				S_REM: begin
					if (idx_q == '0) begin
						out_id_q <= spq_pkg::ID_W'(rd_id_q);
						out_pr_q <= spq_pkg::PRIO_W'(rd_pr_q);
					end
					if (more) begin
						idx_q <= idx_q + IDX_W'(1);
					end else begin
						cnt_q     <= cnt_q - CNT_W'(1);
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				S_LKP: begin
					if (hit) begin
						out_id_q  <= spq_pkg::ID_W'(rd_id_q);
						out_pr_q  <= spq_pkg::PRIO_W'(rd_pr_q);
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end else if (more) begin
						idx_q <= idx_q + IDX_W'(1);
					end else begin
						out_st_q  <= spq_pkg::ST_NOTFOUND;
						out_vld_q <= 1'b1;
						state_q   <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, spq_pkg::OCC_W'(cnt_q), out_pr_q, out_id_q, out_st_q};

	// count never goes past the capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	// a request is never taken while a result is pending or a scan runs
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready)
		else $error("ready right after accept");

	// count moves by at most one per request and only when a result is raised
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> $rose(out_vld_q))
		else $error("count changed outside request completion");

	// a full refusal reports a full queue
	a_full_occ: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_st_q == spq_pkg::ST_FULL) |-> (cnt_q == CNT_W'(CAPACITY)))
		else $error("full status with room left");

	// no memory access while the result waits in idle
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE && !accept) |-> !mem_we && !mem_re)
		else $error("memory access while idle");

endmodule

>>> tb/spq_checker.sv
// checker for the stable priority queue: predicts each result and compares it field by field
`timescale 1ns / 1ps

module spq_checker #(
	parameter int CAPACITY = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [spq_pkg::IN_W-1:0]  s_tdata,  // command, client_id, priority_req
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [spq_pkg::OUT_W-1:0] m_tdata,  // status, out_id, out_priority, occupancy
	output int                        errors,
	output int                        pending
);

	localparam int REQ_ID_LSB   = spq_pkg::CMD_W;
	localparam int REQ_PRIO_LSB = spq_pkg::CMD_W + spq_pkg::ID_W;
	localparam int RES_ID_LSB   = spq_pkg::STATUS_W;
	localparam int RES_PRIO_LSB = spq_pkg::STATUS_W + spq_pkg::ID_W;
	localparam int RES_OCC_LSB  = spq_pkg::STATUS_W + spq_pkg::ID_W + spq_pkg::PRIO_W;
	localparam int HELD_IDX_W   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	typedef struct {
		spq_pkg::status_t           status;
		logic [spq_pkg::ID_W-1:0]   id;
		logic [spq_pkg::PRIO_W-1:0] prio;
		logic [spq_pkg::OCC_W-1:0]  occ;
	} reply_t;

	// model of the queue contents, front at index zero
	logic [spq_pkg::ID_W-1:0]   held_ids   [CAPACITY];
	logic [spq_pkg::PRIO_W-1:0] held_prios [CAPACITY];
	int                         held_count;

	reply_t expected_replies[$];

	function automatic reply_t serve_request(spq_pkg::cmd_t cmd,
			logic [spq_pkg::ID_W-1:0] id, logic [spq_pkg::PRIO_W-1:0] prio);
		reply_t r;
		int     pos;
		int     i;
		bit     hit;
		r = '{spq_pkg::ST_OK, '0, '0, '0};
		case (cmd)
			spq_pkg::CMD_INSERT: begin
				if (held_count >= CAPACITY) begin
					r.status = spq_pkg::ST_FULL;
				end else begin
					// lands behind every entry of equal or smaller priority
					pos = 0;
					while (pos < held_count && held_prios[HELD_IDX_W'(pos)] <= prio)
						pos++;
					for (i = held_count; i > pos; i--) begin
						held_ids[HELD_IDX_W'(i)]   = held_ids[HELD_IDX_W'(i-1)];
						held_prios[HELD_IDX_W'(i)] = held_prios[HELD_IDX_W'(i-1)];
					end
					held_ids[HELD_IDX_W'(pos)]   = id;
					held_prios[HELD_IDX_W'(pos)] = prio;
					held_count++;
				end
			end
			spq_pkg::CMD_REMOVE: begin
				if (held_count == 0) begin
					r.status = spq_pkg::ST_EMPTY;
				end else begin
					r.id   = held_ids[0];
					r.prio = held_prios[0];
					for (i = 1; i < held_count; i++) begin
						held_ids[HELD_IDX_W'(i-1)]   = held_ids[HELD_IDX_W'(i)];
						held_prios[HELD_IDX_W'(i-1)] = held_prios[HELD_IDX_W'(i)];
					end
					held_count--;
				end
			end
			spq_pkg::CMD_LOOKUP: begin
				r.status = spq_pkg::ST_NOTFOUND;
				hit = 1'b0;
				for (i = 0; i < held_count && !hit; i++) begin
					if (held_ids[HELD_IDX_W'(i)] == id) begin
						hit      = 1'b1;
						r.status = spq_pkg::ST_OK;
						r.id     = held_ids[HELD_IDX_W'(i)];
						r.prio   = held_prios[HELD_IDX_W'(i)];
					end
				end
			end
			default: ;
		endcase
		r.occ = spq_pkg::OCC_W'(held_count);
		return r;
	endfunction

	function automatic bit field_differs(string name, logic [spq_pkg::ID_W-1:0] want,
			logic [spq_pkg::ID_W-1:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// sampled mid-cycle, so the values seen are the ones the next rising edge takes
	always @(negedge clk) begin : watch_channels
		reply_t want;
		bit     bad;
		if (arst_n) begin
			if (s_tvalid && s_tready)
				expected_replies.push_back(serve_request(s_tdata[spq_pkg::CMD_W-1:0],
					s_tdata[REQ_ID_LSB +: spq_pkg::ID_W],
					s_tdata[REQ_PRIO_LSB +: spq_pkg::PRIO_W]));
			if (m_tvalid && m_tready) begin
				if (expected_replies.size() == 0) begin
					$display("%0t: result with none expected, actual %0h", $time, m_tdata);
					errors++;
				end else begin
					want = expected_replies.pop_front();
					bad  = 1'b0;
					bad |= field_differs("status", spq_pkg::ID_W'(want.status),
						spq_pkg::ID_W'(m_tdata[spq_pkg::STATUS_W-1:0]));
					bad |= field_differs("out_id", want.id,
						m_tdata[RES_ID_LSB +: spq_pkg::ID_W]);
					bad |= field_differs("out_priority", spq_pkg::ID_W'(want.prio),
						spq_pkg::ID_W'(m_tdata[RES_PRIO_LSB +: spq_pkg::PRIO_W]));
					bad |= field_differs("occupancy", spq_pkg::ID_W'(want.occ),
						spq_pkg::ID_W'(m_tdata[RES_OCC_LSB +: spq_pkg::OCC_W]));
					if (bad)
						errors++;
				end
			end
			pending = expected_replies.size();
		end
	end

endmodule

>>> tb/tb_stable_priority_queue.sv
// testbench top for the stable priority queue: stimulus, flow control and verdict
`timescale 1ns / 1ps

module tb_stable_priority_queue;

	localparam spq_pkg::cmd_t CMD_UNUSED     = 2'd3;
	localparam int            HOLD_CYCLES    = 400;
	localparam int            WATCHDOG_LIMIT = 5000;
	localparam int            DRAIN_CYCLES   = 40;

	logic                      clk      = 1'b0;
	logic                      arst_n   = 1'b0;
	logic                      s_tvalid = 1'b0;
	logic [spq_pkg::IN_W-1:0]  s_tdata  = '0;
	logic                      m_tready = 1'b0;
	logic                      s_tready;
	logic                      m_tvalid;
	logic [spq_pkg::OUT_W-1:0] m_tdata;

	int errors;
	int pending;
	int idle_pct     = 0;
	int stall_pct    = 0;
	int hold_req     = 0;
	int hold_seen    = 0;
	int hold_left    = 0;
	int quiet_cycles = 0;
	int insert_bias  = 50;
	logic [2:0] recent_wr = '0;

	// ids inserted lately, reused for lookup hits and duplicate ids
	logic [spq_pkg::ID_W-1:0] recent_ids [8] = '{default: '0};

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	stable_priority_queue u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	spq_checker u_checker (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.errors   (errors),
		.pending  (pending)
	);

	// result side: random stalls, or a long hold-off when one is requested
	always @(posedge clk) begin
		if (hold_left != 0) begin
			m_tready  <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_seen) begin
			m_tready  <= 1'b0;
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= stall_pct);
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	task automatic send_request(spq_pkg::cmd_t cmd, logic [spq_pkg::ID_W-1:0] id,
			logic [spq_pkg::PRIO_W-1:0] prio);
		bit took;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(spq_pkg::IN_W-spq_pkg::CMD_W-spq_pkg::ID_W-spq_pkg::PRIO_W){1'b0}},
			prio, id, cmd};
		do begin
			@(negedge clk);
			took = s_tready;
			@(posedge clk);
		end while (!took);
		if (cmd == spq_pkg::CMD_INSERT) begin
			recent_ids[recent_wr] = id;
			recent_wr = recent_wr + 3'd1;
		end
	endtask

	// stop offering items until every result is back
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		wait (pending == 0);
		@(posedge clk);
	endtask

	task automatic run_phase(int count, int idle, int stall, bit with_hold);
		spq_pkg::cmd_t              cmd;
		logic [spq_pkg::ID_W-1:0]   id;
		logic [spq_pkg::PRIO_W-1:0] prio;
		int                         pick;
		int                         k;
		idle_pct  = idle;
		stall_pct = stall;
		for (k = 0; k < count; k++) begin
			// swing between filling and draining so full and empty both come up
			if (k % 32 == 0)
				insert_bias = $urandom_range(15, 85);
			if (with_hold && k == count / 2)
				hold_req++;
			pick = $urandom_range(0, 99);
			if (pick < 3) begin
				cmd = CMD_UNUSED;
			end else begin
				pick = $urandom_range(0, 99);
				if (pick < insert_bias)
					cmd = spq_pkg::CMD_INSERT;
				else if (pick < insert_bias + (100 - insert_bias) / 2)
					cmd = spq_pkg::CMD_REMOVE;
				else
					cmd = spq_pkg::CMD_LOOKUP;
			end
			pick = $urandom_range(0, 99);
			if ((cmd == spq_pkg::CMD_LOOKUP && pick < 70) ||
					(cmd != spq_pkg::CMD_LOOKUP && pick < 25))
				id = recent_ids[3'($urandom_range(0, 7))];
			else
				id = $urandom;
			case ($urandom_range(0, 3))
				0:       prio = spq_pkg::PRIO_W'($urandom_range(0, 3));
				1:       prio = $urandom_range(0, 1) ? '1 : '0;
				default: prio = spq_pkg::PRIO_W'($urandom_range(0, 255));
			endcase
			send_request(cmd, id, prio);
		end
		wait_drained();
	endtask

	initial begin
		int k;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty queue, unused code, extremes, ties and a duplicate id
		send_request(spq_pkg::CMD_REMOVE, '1, '1);
		send_request(spq_pkg::CMD_LOOKUP, '0, '0);
		send_request(CMD_UNUSED, '1, '1);
		send_request(spq_pkg::CMD_INSERT, '0, '1);
		send_request(spq_pkg::CMD_INSERT, '1, '0);
		send_request(spq_pkg::CMD_INSERT, 32'd5, '1);
		send_request(spq_pkg::CMD_INSERT, 32'd5, 8'd7);
		send_request(spq_pkg::CMD_LOOKUP, 32'd5, '0);
		send_request(spq_pkg::CMD_LOOKUP, 32'h0001_2345, '0);
		send_request(spq_pkg::CMD_LOOKUP, '1, '0);
		// fill up with one shared priority, then one more insert than fits
		for (k = 0; k < 13; k++)
			send_request(spq_pkg::CMD_INSERT, 32'h1000_0000 + k, 8'd100);
		send_request(spq_pkg::CMD_REMOVE, '0, '0);
		send_request(CMD_UNUSED, '0, '0);
		wait_drained();

		run_phase(170, 0, 0, 1'b1);
		run_phase(160, 79, 0, 1'b0);
		run_phase(160, 0, 79, 1'b1);
		run_phase(160, 12, 12, 1'b0);

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && pending == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> sim.f
design/spq_pkg.sv
design/stable_priority_queue.sv
tb/spq_checker.sv
tb/tb_stable_priority_queue.sv
